/* rtl/pfe_pkg.sv */
`timescale 1ns / 1ps
// Types and constants shared by the protobuf field encoder.
// No dependencies.
package pfe_pkg;

    localparam int unsigned FNUM_W  = 29;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned TAG_W   = FNUM_W + 3;
    localparam int unsigned CNT_W   = 4;

    localparam logic [6:0] VAR_PAYLOAD_MASK = 7'h7F;
    localparam logic [7:0] VAR_CONT_BIT     = 8'h80;
    localparam logic [7:0] BYTE_MASK        = 8'hFF;

    // Field kinds on the request.
    typedef enum logic [1:0] {
        CMD_VARINT   = 2'd0,
        CMD_FIXED32  = 2'd1,
        CMD_FIXED64  = 2'd2,
        CMD_RESERVED = 2'd3
    } t_cmd;

    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    localparam logic [CNT_W-1:0] FIXED32_BYTES = 4'd4;
    localparam logic [CNT_W-1:0] FIXED64_BYTES = 4'd8;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic emit_tag;
        logic emit_val;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic tag_last;
        logic val_last;
    } t_dp_sts;

    function automatic logic [2:0] wire_type(input t_cmd cmd);
        logic [2:0] w;
        unique case (cmd)
            CMD_VARINT:  w = WIRE_VARINT;
            CMD_FIXED32: w = WIRE_FIXED32;
            CMD_FIXED64: w = WIRE_FIXED64;
            default:     w = WIRE_VARINT;
        endcase
        return w;
    endfunction

endpackage

/* rtl/pfe_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the protobuf field encoder: load, tag bytes, value bytes.
// Depends on pfe_pkg.
module pfe_ctrl import pfe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_cmd    i_cmd,
    output logic    o_stall,
    output t_dp_cmd o_dp_cmd,
    input  t_dp_sts i_dp_sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TAG  = 3'b010,
        ST_VAL  = 3'b100
    } t_state;

    t_state r_state, n_state;

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                // reserved command: take the beat and drop it
                if (i_valid && (i_cmd != CMD_RESERVED)) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = ST_TAG;
                end
            end
            ST_TAG: begin
                if (i_dp_sts.out_free) begin
                    o_dp_cmd.emit_tag = 1'b1;
                    if (i_dp_sts.tag_last) begin
                        n_state = ST_VAL;
                    end
                end
            end
            ST_VAL: begin
                if (i_dp_sts.out_free) begin
                    o_dp_cmd.emit_val = 1'b1;
                    if (i_dp_sts.val_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/pfe_dp.sv */
`timescale 1ns / 1ps
// Datapath of the protobuf field encoder: tag and value shifters, output register.
// Depends on pfe_pkg.
module pfe_dp import pfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [FNUM_W-1:0]  i_field_number,
    input  logic [VALUE_W-1:0] i_field_value,
    input  t_dp_cmd            i_dp_cmd,
    output t_dp_sts            o_dp_sts,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);

    logic [TAG_W-1:0]   r_tag;
    logic [VALUE_W-1:0] r_val;
    logic [CNT_W-1:0]   r_cnt;
    t_cmd               r_kind;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic       tag_more;
    logic       val_more;
    logic [7:0] tag_byte;
    logic [7:0] val_byte;

    assign tag_more = (r_tag[TAG_W-1:7] != '0);
    assign val_more = (r_val[VALUE_W-1:7] != '0);

    assign tag_byte = tag_more ? ({1'b0, r_tag[6:0] & VAR_PAYLOAD_MASK} | VAR_CONT_BIT)
                               : {1'b0, r_tag[6:0]};

    always_comb begin
        if (r_kind == CMD_VARINT) begin
            val_byte = val_more ? ({1'b0, r_val[6:0] & VAR_PAYLOAD_MASK} | VAR_CONT_BIT)
                                : {1'b0, r_val[6:0]};
        end else begin
            val_byte = r_val[7:0] & BYTE_MASK;
        end
    end

    assign o_dp_sts.out_free = !r_out_valid || !i_stall;
    assign o_dp_sts.tag_last = !tag_more;
    assign o_dp_sts.val_last = (r_kind == CMD_VARINT) ? !val_more : (r_cnt == 4'd1);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_tag  <= {i_field_number, wire_type(i_cmd)};
            r_val  <= i_field_value;
            r_kind <= i_cmd;
            r_cnt  <= (i_cmd == CMD_FIXED32) ? FIXED32_BYTES : FIXED64_BYTES;
        end
        if (i_dp_cmd.emit_tag) begin
            r_tag <= r_tag >> 7;
        end
        if (i_dp_cmd.emit_val) begin
            r_val <= (r_kind == CMD_VARINT) ? (r_val >> 7) : (r_val >> 8);
            r_cnt <= r_cnt - 4'd1;
        end
        // payload of the output register
        if (i_dp_cmd.emit_tag) begin
            r_out_byte <= tag_byte;
            r_out_last <= 1'b0;
        end else if (i_dp_cmd.emit_val) begin
            r_out_byte <= val_byte;
            r_out_last <= o_dp_sts.val_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.emit_tag || i_dp_cmd.emit_val) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

/* rtl/protobuf_field_encoder_top.sv */
`timescale 1ns / 1ps
// Top level of the protobuf field encoder: sequencer plus datapath.
// Depends on pfe_pkg, pfe_ctrl and pfe_dp.

// Each request beat (varint, fixed32 or fixed64 field) becomes a stream of output
// beats: the tag varint of one to five bytes, then the value bytes (one to ten for
// varint, four or eight little-endian for fixed32 and fixed64); o_last marks the
// final byte. A request is loaded first; its bytes then pass one at a time through
// the single byte-wide output register, which emits one byte per cycle while it is
// not held by i_stall; o_stall is high until the last byte has entered that
// register. A request with the reserved command code is taken and produces
// nothing.
module protobuf_field_encoder_top import pfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [FNUM_W-1:0]  i_field_number,
    input  logic [VALUE_W-1:0] i_field_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_cmd    cmd;

    assign cmd = t_cmd'(i_cmd);

    pfe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (cmd),
        .o_stall  (o_stall),
        .o_dp_cmd (dp_cmd),
        .i_dp_sts (dp_sts)
    );

    pfe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_field_number (i_field_number),
        .i_field_value  (i_field_value),
        .i_dp_cmd       (dp_cmd),
        .o_dp_sts       (dp_sts),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

endmodule

/* rtl/pfe_chk.sv */
`timescale 1ns / 1ps
// Port-level checks for the protobuf field encoder, bound to its top level.
// Depends on pfe_pkg and protobuf_field_encoder_top.
module pfe_chk import pfe_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_cmd,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    // held output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("encoder busy right after reset");

    // a real request keeps the input side stalled while its bytes go out
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd != CMD_RESERVED) |=> o_stall)
        else $error("request accepted but encoder not busy");

    // reserved command is dropped
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd == CMD_RESERVED) |=> !o_stall)
        else $error("reserved command not dropped");

endmodule

bind protobuf_field_encoder_top pfe_chk u_pfe_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_cmd      (i_cmd),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);

/* tb/sv/protobuf_field_encoder_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for protobuf_field_encoder_top: field requests in, encoded bytes out.
// Depends on pfe_pkg and the encoder RTL.
module protobuf_field_encoder_top_test;
    import pfe_pkg::*;

    localparam int unsigned FIELD_COUNT   = 240;
    localparam int unsigned DRAIN_AT      = 130;
    localparam int unsigned CALM_TAIL     = 40;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned STUCK_LIMIT   = 1000;

    typedef struct {
        t_cmd               cmd;
        logic [FNUM_W-1:0]  fnum;
        logic [VALUE_W-1:0] value;
        bit                 drain_first;
    } t_field_req;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
    } t_enc_byte;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic [1:0]         i_cmd          = CMD_VARINT;
    logic [FNUM_W-1:0]  i_field_number = '0;
    logic [VALUE_W-1:0] i_field_value  = '0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic [7:0]         o_out_byte;
    logic               o_last;

    t_field_req  field_reqs[$];
    t_enc_byte   enc_bytes[$];
    bit          req_beat     = 1'b0;
    int unsigned src_gap      = 0;
    int unsigned snk_gap      = 0;
    int unsigned stuck_cycles = 0;
    int unsigned error_cnt    = 0;

    protobuf_field_encoder_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_field_number (i_field_number),
        .i_field_value  (i_field_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void append_byte(t_enc_byte b);
        enc_bytes = {enc_bytes, b};
    endfunction

    function automatic void queue_varint(logic [63:0] v);
        logic [63:0] rest;
        rest = v;
        while (rest > 64'(VAR_PAYLOAD_MASK)) begin
            append_byte('{out_byte: VAR_CONT_BIT | {1'b0, rest[6:0]}, last: 1'b0});
            rest = rest >> 7;
        end
        append_byte('{out_byte: rest[7:0], last: 1'b0});
    endfunction

    function automatic void queue_le(logic [63:0] v, int unsigned nbytes);
        for (int unsigned i = 0; i < nbytes; i++) begin
            append_byte('{out_byte: v[8*i +: 8], last: 1'b0});
        end
    endfunction

    // Append the expected byte stream of one field request.
    function automatic void encode_field(t_cmd cmd, logic [FNUM_W-1:0] fnum,
                                         logic [VALUE_W-1:0] value);
        logic [2:0] wt;
        case (cmd)
            CMD_VARINT:  wt = WIRE_VARINT;
            CMD_FIXED32: wt = WIRE_FIXED32;
            CMD_FIXED64: wt = WIRE_FIXED64;
            default:     return;
        endcase
        queue_varint(64'({fnum, wt}));
        case (cmd)
            CMD_VARINT:  queue_varint(value);
            CMD_FIXED32: queue_le(value, 4);
            default:     queue_le(value, 8);
        endcase
        enc_bytes[enc_bytes.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_field(t_cmd cmd, logic [FNUM_W-1:0] fnum,
                                      logic [VALUE_W-1:0] value, bit drain_first);
        t_field_req req;
        req = '{cmd: cmd, fnum: fnum, value: value, drain_first: drain_first};
        field_reqs = {field_reqs, req};
    endfunction

    // Spread bit lengths so short and long varints both show up.
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom(), $urandom()};
        if ($urandom_range(0, 9) == 0) begin
            return v;
        end
        return v >> $urandom_range(0, 63);
    endfunction

    function automatic logic [FNUM_W-1:0] rand_fnum();
        logic [31:0] v;
        v = $urandom();
        return v[FNUM_W-1:0] >> $urandom_range(0, FNUM_W - 1);
    endfunction

    function automatic bit calm_phase();
        return field_reqs.size() < CALM_TAIL || (field_reqs.size() / 30) % 3 == 0;
    endfunction

    // Request driver.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_beat) begin
                field_reqs.delete(0);
            end
            if (i_valid && !req_beat) begin
                // hold the stalled beat
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_valid <= 1'b0;
            end else if (field_reqs.size() == 0) begin
                i_valid <= 1'b0;
            end else if (field_reqs[0].drain_first && enc_bytes.size() != 0) begin
                i_valid <= 1'b0;
            end else if (!calm_phase() && $urandom_range(0, 3) == 0) begin
                src_gap <= $urandom_range(0, 3);
                i_valid <= 1'b0;
            end else begin
                i_valid        <= 1'b1;
                i_cmd          <= field_reqs[0].cmd;
                i_field_number <= field_reqs[0].fnum;
                i_field_value  <= field_reqs[0].value;
            end
        end
    end

    // Output back-pressure.
    always @(negedge i_clk) begin
        if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            i_stall <= 1'b1;
        end else if (!calm_phase() && $urandom_range(0, 4) == 0) begin
            snk_gap <= $urandom_range(0, 3);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor, checker and watchdog.
    always @(posedge i_clk) begin : monitor
        t_enc_byte want;
        bit        in_beat;
        bit        out_beat;
        in_beat  = i_rst_n && i_valid && !o_stall;
        out_beat = i_rst_n && o_valid && !i_stall;
        req_beat <= in_beat;
        if (in_beat) begin
            encode_field(t_cmd'(i_cmd), i_field_number, i_field_value);
        end
        if (out_beat) begin
            if (enc_bytes.size() == 0) begin
                $error("unexpected output beat: out_byte %02h last %0b", o_out_byte, o_last);
                error_cnt++;
            end else begin
                want = enc_bytes.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, o_out_byte);
                    error_cnt++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    error_cnt++;
                end
            end
        end
        if (in_beat || out_beat) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned n_fields;
        t_cmd        cmd;
        // Extremes, tag length boundaries, value boundaries, reserved command.
        add_field(CMD_VARINT,   29'd0,         64'd0, 1'b0);
        add_field(CMD_VARINT,   '1,            '1, 1'b0);
        add_field(CMD_FIXED32,  29'd0,         '1, 1'b0);
        add_field(CMD_FIXED64,  '1,            '1, 1'b0);
        add_field(CMD_FIXED64,  29'd1,         64'd0, 1'b0);
        add_field(CMD_FIXED32,  29'd15,        64'hFFFF_FFFF_89AB_CDEF, 1'b0);
        add_field(CMD_FIXED32,  29'd16,        64'd0, 1'b0);
        add_field(CMD_VARINT,   29'd16,        64'h7F, 1'b0);
        add_field(CMD_VARINT,   29'd2047,      64'h80, 1'b0);
        add_field(CMD_VARINT,   29'd2048,      64'h3FFF, 1'b0);
        add_field(CMD_VARINT,   29'h3_FFFF,    64'h4000, 1'b0);
        add_field(CMD_VARINT,   29'h4_0000,    64'h8000_0000_0000_0000, 1'b0);
        add_field(CMD_VARINT,   29'h1FF_FFFF,  64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        add_field(CMD_VARINT,   29'h200_0000,  64'd1, 1'b0);
        add_field(CMD_RESERVED, '1,            '1, 1'b0);
        add_field(CMD_RESERVED, 29'd0,         64'd0, 1'b0);
        add_field(CMD_FIXED64,  29'h0AAA_AAAA, 64'h0123_4567_89AB_CDEF, 1'b0);
        add_field(CMD_FIXED64,  29'h1555_5555, 64'hFEDC_BA98_7654_3210, 1'b0);
        add_field(CMD_VARINT,   29'd1,         64'h0FFF_FFFF_FFFF_FFFF, 1'b0);
        add_field(CMD_FIXED32,  '1,            64'h0000_0000_8000_0001, 1'b0);

        n_fields = 0;
        while (n_fields < FIELD_COUNT) begin
            cmd = t_cmd'($urandom_range(0, 2));
            if ($urandom_range(0, 19) == 0) begin
                cmd = CMD_RESERVED;
            end
            add_field(cmd, rand_fnum(), rand_value(), n_fields == DRAIN_AT);
            n_fields++;
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (field_reqs.size() == 0 && !i_valid);
        wait (enc_bytes.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_cnt == 0 && enc_bytes.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/pfe_pkg.sv
rtl/pfe_ctrl.sv
rtl/pfe_dp.sv
rtl/protobuf_field_encoder_top.sv
rtl/pfe_chk.sv
tb/sv/protobuf_field_encoder_top_test.sv
